@@ rtl/indexed_insert_remove_list_defines.svh @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_defines.svh
// Assertion macros for the indexed list block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define IXL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define IXL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IXL_ASSERT_NOW(lbl, ante, cons, msg)

`define IXL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/ixl_pkg.sv @@
// ----------------------------------------------------------------------------
// ixl_pkg
// Shared types, codes and widths of the indexed list block.
// ----------------------------------------------------------------------------
package ixl_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;
  localparam int MAX_CAPACITY   = 256;

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 5;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 5;
  localparam int STAT_W  = 2;
  localparam int POS_W   = $clog2(MAX_CAPACITY + 1);

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD   = 2'd0;
  localparam cell_op_t CELL_INSERT = 2'd1;
  localparam cell_op_t CELL_REMOVE = 2'd2;
  localparam cell_op_t CELL_WRITE  = 2'd3;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
  } cell_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic [STAT_W-1:0]  status;
  } resp_t;

endpackage

@@ rtl/indexed_insert_remove_list.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Bounded ordered list built as a row of cells that shift in place.
// The result strobe rises in the cycle after the start transfer.
// Throughput: one request per cycle; every cell shifts in the same cycle.
// busy stays low, since each request finishes in the cycle that takes it.
// Reset (rst_n low, synchronous) empties the list; stored words are not cleared.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list #(
  parameter int CAPACITY   = ixl_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = ixl_pkg::DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ixl_pkg::FUNC_W-1:0]   in_func,
  input  logic [ixl_pkg::IDX_W-1:0]    in_index,
  input  logic [ixl_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  output logic [ixl_pkg::VALUE_W-1:0]  out_read_value,
  output logic [ixl_pkg::CNT_W-1:0]    out_count,
  output logic                         out_is_empty,
  output logic [ixl_pkg::STAT_W-1:0]   out_status
);
  import ixl_pkg::*;

  `include "indexed_insert_remove_list_defines.svh"

  localparam int CNT_IW = $clog2(CAPACITY + 1);
  localparam int AW     = $clog2(CAPACITY);

  logic                  accept;
  cell_cmd_t             cmd;
  logic                  rd_en;
  resp_t                 resp;
  logic [CNT_IW-1:0]     count;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [VALUE_W-1:0]    read_value_r;
  logic [VALUE_W-1:0]    read_value_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign wdata  = DATA_WIDTH'(in_value);

  ixl_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_IW   (CNT_IW)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_func),
    .index  (in_index),
    .cmd    (cmd),
    .rd_en  (rd_en),
    .resp   (resp),
    .count  (count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q;
    logic [DATA_WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    ixl_cell #(
      .POS        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .wdata   (wdata),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i])
    );
  end

  always_comb begin
    read_value_nxt = '0;
    if (rd_en) begin
      read_value_nxt = VALUE_W'(cell_q[cmd.pos[AW-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    read_value_r <= read_value_nxt;
  end

  assign out_valid      = resp.valid;
  assign out_read_value = read_value_r;
  assign out_count      = resp.count;
  assign out_is_empty   = resp.is_empty;
  assign out_status     = resp.status;

  `IXL_ASSERT_NEXT(a_strobe_follows, accept, out_valid, "result strobe missing after transfer")
  `IXL_ASSERT_NEXT(a_no_stray_strobe, !accept, !out_valid, "result strobe without transfer")
  `IXL_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_IW'(CAPACITY), "element count above capacity")
  `IXL_ASSERT_NOW(a_full_count, out_valid && out_status == ST_FULL, count == CNT_IW'(CAPACITY), "full status while list not full")
  `IXL_ASSERT_NOW(a_reject_zero, out_valid && out_status != ST_OK, out_read_value == '0, "rejected request returns data")

endmodule

@@ rtl/ixl_cell.sv @@
// ----------------------------------------------------------------------------
// ixl_cell
// One list position: holds, loads from a neighbor, or takes new data.
// ----------------------------------------------------------------------------
module ixl_cell #(
  parameter int POS        = 0,
  parameter int DATA_WIDTH = ixl_pkg::DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  ixl_pkg::cell_cmd_t    cmd,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  output logic [DATA_WIDTH-1:0] q
);
  import ixl_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_POS == cmd.pos) begin
          data_nxt = wdata;
        end else if (MY_POS > cmd.pos) begin
          data_nxt = left_q;
        end
      end
      CELL_REMOVE: begin
        if (MY_POS >= cmd.pos) begin
          data_nxt = right_q;
        end
      end
      CELL_WRITE: begin
        if (MY_POS == cmd.pos) begin
          data_nxt = wdata;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

@@ rtl/ixl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ixl_ctrl
// Element count, request checks, cell command and response register.
// ----------------------------------------------------------------------------
module ixl_ctrl #(
  parameter int CAPACITY = ixl_pkg::DEF_CAPACITY,
  parameter int CNT_IW   = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ixl_pkg::FUNC_W-1:0]  func,
  input  logic [ixl_pkg::IDX_W-1:0]   index,
  output ixl_pkg::cell_cmd_t          cmd,
  output logic                        rd_en,
  output ixl_pkg::resp_t              resp,
  output logic [CNT_IW-1:0]           count
);
  import ixl_pkg::*;

  localparam logic [CNT_IW-1:0] FULL_CNT = CNT_IW'(CAPACITY);

  logic [CNT_IW-1:0] count_r;
  logic [CNT_IW-1:0] count_nxt;
  resp_t             resp_r;
  resp_t             resp_nxt;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  cnt_p;
  logic              full;

  assign pos   = POS_W'(index);
  assign cnt_p = POS_W'(count_r);
  assign full  = (count_r == FULL_CNT);

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    cmd.op    = CELL_HOLD;
    cmd.pos   = pos;
    rd_en     = 1'b0;
    if (accept) begin
      case (func)
        FN_APPEND: begin
          if (full) begin
            status = ST_FULL;
          end else begin
            cmd.op    = CELL_INSERT;
            cmd.pos   = cnt_p;
            count_nxt = count_r + 1'b1;
          end
        end
        FN_INSERT: begin
          if (full) begin
            status = ST_FULL;
          end else if (pos > cnt_p) begin
            status = ST_BADIDX;
          end else begin
            cmd.op    = CELL_INSERT;
            count_nxt = count_r + 1'b1;
          end
        end
        FN_REMOVE: begin
          if (pos >= cnt_p) begin
            status = ST_BADIDX;
          end else begin
            cmd.op    = CELL_REMOVE;
            count_nxt = count_r - 1'b1;
          end
        end
        FN_SET: begin
          if (pos >= cnt_p) begin
            status = ST_BADIDX;
          end else begin
            cmd.op = CELL_WRITE;
          end
        end
        FN_GET: begin
          if (pos >= cnt_p) begin
            status = ST_BADIDX;
          end else begin
            rd_en = 1'b1;
          end
        end
        FN_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    resp_nxt.valid    = accept;
    resp_nxt.count    = CNT_W'(count_nxt);
    resp_nxt.is_empty = (count_nxt == '0);
    resp_nxt.status   = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      resp_r  <= '0;
    end else begin
      count_r <= count_nxt;
      resp_r  <= resp_nxt;
    end
  end

  assign resp  = resp_r;
  assign count = count_r;

endmodule

@@ sim/tb_indexed_insert_remove_list.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_list
// Self-checking testbench for the bounded indexed list. A queue of requests
// (directed corner cases first, then random bursts that grow, shrink or mix
// the list) feeds a clocked driver. A clocked monitor predicts every accepted
// request with its own copy of the list and compares each strobed result,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_list;
  timeunit 1ns;
  timeprecision 1ps;

  import ixl_pkg::*;

  localparam int LIST_CAP     = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 60000;

  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [IDX_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    int                 idle_pct;
  } list_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]   count;
    logic               is_empty;
    logic [STAT_W-1:0]  status;
  } list_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [FUNC_W-1:0]  in_func;
  logic [IDX_W-1:0]   in_index;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic [VALUE_W-1:0] out_read_value;
  logic [CNT_W-1:0]   out_count;
  logic               out_is_empty;
  logic [STAT_W-1:0]  out_status;

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  list_req_t    next_req;
  list_result_t predicted;

  logic [VALUE_W-1:0] list_mem [LIST_CAP];
  int                 list_len;
  int                 gen_len;
  logic               took;

  int errors;
  int cycle_cnt;
  int n_xfer;
  int n_checked;
  int n_full;
  int n_badidx;
  int n_at_cap;

  indexed_insert_remove_list DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic predict_list_op(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                                 input logic [VALUE_W-1:0] val, output list_result_t res);
    int pos;
    pos = int'(idx);
    res.read_value = '0;
    res.status     = ST_OK;
    case (fn)
      FN_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      FN_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (pos > list_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      FN_REMOVE: begin
        if (pos >= list_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = pos + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      FN_SET: begin
        if (pos >= list_len) res.status = ST_BADIDX;
        else list_mem[pos] = val;
      end
      FN_GET: begin
        if (pos >= list_len) res.status = ST_BADIDX;
        else res.read_value = list_mem[pos];
      end
      FN_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.count    = CNT_W'(list_len);
    res.is_empty = (list_len == 0);
  endtask

  // track the length the queued requests will leave, so indexes can be aimed
  task automatic queue_req(input logic [FUNC_W-1:0] fn, input int idx,
                           input logic [VALUE_W-1:0] val, input int pct);
    list_req_t r;
    r.func     = fn;
    r.index    = IDX_W'(idx);
    r.value    = val;
    r.idle_pct = pct;
    pending_reqs.push_back(r);
    case (fn)
      FN_APPEND: if (gen_len < LIST_CAP) gen_len++;
      FN_INSERT: if (gen_len < LIST_CAP && int'(r.index) <= gen_len) gen_len++;
      FN_REMOVE: if (int'(r.index) < gen_len) gen_len--;
      FN_CLEAR:  gen_len = 0;
      default: begin
      end
    endcase
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  function automatic int pick_index(input logic [FUNC_W-1:0] fn);
    if ($urandom_range(99) < 15) return $urandom_range(31);
    if (fn == FN_INSERT) return $urandom_range(gen_len);
    if (gen_len == 0) return 0;
    return $urandom_range(gen_len - 1);
  endfunction

  // driver: present the next request at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_func  <= '0;
      in_index <= '0;
      in_value <= '0;
    end else if (!start || took) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        next_req = pending_reqs.pop_front();
        start    <= 1'b1;
        in_func  <= next_req.func;
        in_index <= next_req.index;
        in_value <= next_req.value;
      end else begin
        start    <= 1'b0;
        in_func  <= FUNC_W'($urandom);
        in_index <= IDX_W'($urandom);
        in_value <= $urandom;
      end
    end
  end

  // monitor: check strobed results, then predict the request taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: count %0d status %0d",
                 out_count, out_status);
          errors++;
        end else begin
          predicted = expected_results.pop_front();
          n_checked++;
          if (out_read_value !== predicted.read_value) begin
            $error("read_value expected %h actual %h", predicted.read_value, out_read_value);
            errors++;
          end
          if (out_count !== predicted.count) begin
            $error("count expected %0d actual %0d", predicted.count, out_count);
            errors++;
          end
          if (out_is_empty !== predicted.is_empty) begin
            $error("is_empty expected %0b actual %0b", predicted.is_empty, out_is_empty);
            errors++;
          end
          if (out_status !== predicted.status) begin
            $error("status expected %0d actual %0d", predicted.status, out_status);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predict_list_op(in_func, in_index, in_value, predicted);
        expected_results.push_back(predicted);
        n_xfer++;
        if (predicted.status == ST_FULL) n_full++;
        if (predicted.status == ST_BADIDX) n_badidx++;
        if (int'(predicted.count) == LIST_CAP) n_at_cap++;
        took <= 1'b1;
      end else begin
        took <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int mode;
    int burst_left;
    int pct;
    int r;
    logic [FUNC_W-1:0] fn;
    int idle_by_phase [4];

    idle_by_phase = '{0, 59, 20, 0};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_func   = '0;
    in_index  = '0;
    in_value  = '0;
    took      = 1'b0;
    list_len  = 0;
    gen_len   = 0;
    errors    = 0;
    cycle_cnt = 0;
    n_xfer    = 0;
    n_checked = 0;
    n_full    = 0;
    n_badidx  = 0;
    n_at_cap  = 0;
    foreach (list_mem[i]) list_mem[i] = '0;

    queue_req(FN_GET,    0, '0, 0);
    queue_req(FN_REMOVE, 0, '0, 0);
    queue_req(FN_SET,    0, 32'h1234_5678, 0);
    queue_req(FN_INSERT, 1, 32'h0BAD_0BAD, 0);
    queue_req(FN_INSERT, 0, '1, 0);
    queue_req(FN_APPEND, 0, '0, 0);
    queue_req(FN_INSERT, 2, 32'h5A5A_A5A5, 0);
    queue_req(FN_INSERT, 1, 32'hA5A5_5A5A, 0);
    queue_req(FN_GET,    31, '0, 0);
    queue_req(FN_RSVD6,  0, '1, 0);
    queue_req(FN_RSVD7,  31, '1, 0);
    queue_req(FN_SET,    1, 32'hDEAD_BEEF, 0);
    queue_req(FN_GET,    1, '0, 0);
    queue_req(FN_REMOVE, 0, '0, 0);
    queue_req(FN_REMOVE, 2, '0, 0);
    queue_req(FN_GET,    2, '0, 0);
    queue_req(FN_CLEAR,  0, '0, 0);
    queue_req(FN_GET,    0, '0, 0);
    for (int i = 0; i < LIST_CAP; i++) queue_req(FN_INSERT, 0, pick_value(), 0);
    queue_req(FN_APPEND, 0, '1, 0);
    queue_req(FN_INSERT, 31, '1, 0);
    queue_req(FN_GET,    LIST_CAP - 1, '0, 0);
    queue_req(FN_GET,    LIST_CAP, '0, 0);
    queue_req(FN_REMOVE, LIST_CAP - 1, '0, 0);

    n_rand     = 0;
    burst_left = 0;
    mode       = MODE_MIXED;
    while (n_rand < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(MODE_MIXED);
        burst_left = $urandom_range(30, 8);
      end
      burst_left--;
      pct = idle_by_phase[(n_rand * 4) / RANDOM_ITEMS];
      r   = $urandom_range(99);
      case (mode)
        MODE_GROW:
          fn = (r < 40) ? FN_APPEND : (r < 70) ? FN_INSERT : (r < 80) ? FN_SET :
               (r < 92) ? FN_GET : (r < 96) ? FN_REMOVE : (r < 98) ? FN_CLEAR : FN_RSVD6;
        MODE_SHRINK:
          fn = (r < 45) ? FN_REMOVE : (r < 60) ? FN_GET : (r < 70) ? FN_SET :
               (r < 80) ? FN_INSERT : (r < 88) ? FN_APPEND : (r < 91) ? FN_CLEAR : FN_RSVD7;
        default:
          fn = (r < 18) ? FN_APPEND : (r < 36) ? FN_INSERT : (r < 54) ? FN_REMOVE :
               (r < 72) ? FN_SET : (r < 92) ? FN_GET : (r < 96) ? FN_CLEAR :
               (r < 98) ? FN_RSVD6 : FN_RSVD7;
      endcase
      queue_req(fn, pick_index(fn), pick_value(), pct);
      if (fn != FN_RSVD6 && fn != FN_RSVD7) n_rand++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || start || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("transfers %0d, results checked %0d", n_xfer, n_checked);
    $display("full rejections %0d, index rejections %0d, results at capacity %0d",
             n_full, n_badidx, n_at_cap);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ixl_pkg.sv
rtl/ixl_cell.sv
rtl/ixl_ctrl.sv
rtl/indexed_insert_remove_list.sv
sim/tb_indexed_insert_remove_list.sv
